@@ rtl/rob_pkg.sv @@
// ----------------------------------------------------------------------------
// rob_pkg
// shared types and constants of the in-order reorder buffer
// ----------------------------------------------------------------------------
package rob_pkg;

    localparam int DEPTH       = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int SEQ_WIDTH   = 4;
    localparam int IDX_WIDTH   = $clog2(DEPTH);
    localparam int MAX_RESULTS = 16;
    localparam int CNT_WIDTH   = $clog2(MAX_RESULTS);

    // incoming beat
    typedef struct packed {
        logic [SEQ_WIDTH-1:0]  seq_number;
        logic [DATA_WIDTH-1:0] payload;
    } item_t;

    // outgoing beat
    typedef struct packed {
        logic [SEQ_WIDTH-1:0]  out_seq;
        logic [DATA_WIDTH-1:0] out_payload;
        logic                  last_of_run;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic write;
        logic emit;
        logic last;
    } rob_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic head_valid;
        logic next_valid;
        logic out_free;
    } rob_status_t;

endpackage

@@ rtl/in_order_reorder_buffer_unit.sv @@
// ----------------------------------------------------------------------------
// in_order_reorder_buffer_unit
// reorder buffer that restores sequence order of tagged data beats
// ----------------------------------------------------------------------------
// usage:
//   item channel (item_valid / item_stall / item) carries a sequence number
//   and a payload; the payload lands in the slot picked by the sequence
//   number and that slot is marked valid
//   result channel (result_valid / result_stall / result) then releases, in
//   order, every consecutive valid slot starting at the head, one beat per
//   cycle unless result_stall holds it; the final beat released by one
//   item has last_of_run set; at most 16 beats are released per item; the
//   rest wait for the next item
// timing:
//   an item is taken in the idle state, then the drain state releases its
//   beats, and an item that releases none still passes through the drain
//   state; the block takes no new item until that drain ends; the first
//   result beat is issued from the drain state into the output register
// reset:
//   rst_n clears all valid bits, the head and the output valid flag; slot
//   data and the output register's data are not cleared, and slot data
//   are only read once written
// back pressure:
//   a stalled result beat holds in the output register and the drain
//   pauses; item_stall stays high until the drain of the current item ends
module in_order_reorder_buffer_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  rob_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output rob_pkg::result_t result
);

    // command and status between sequencer and datapath
    rob_pkg::rob_cmd_t    cmd;
    rob_pkg::rob_status_t status;

    // sequencer: idle / drain state machine and per-item beat count
    rob_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // slot store, valid bits, head pointer and output register
    rob_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ rtl/rob_ctrl.sv @@
// ----------------------------------------------------------------------------
// rob_ctrl
// sequencer: takes one item, then drains the run of valid slots at the head
// ----------------------------------------------------------------------------
module rob_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  rob_pkg::rob_status_t status,
    output rob_pkg::rob_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } rob_state_t;

    rob_state_t                    state_reg;
    rob_state_t                    state_next;
    logic [rob_pkg::CNT_WIDTH-1:0] cnt_reg;
    logic [rob_pkg::CNT_WIDTH-1:0] cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.write  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.head_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = (cnt_reg == rob_pkg::CNT_WIDTH'(rob_pkg::MAX_RESULTS - 1))
                               || !status.next_valid;
                    cnt_next = rob_pkg::CNT_WIDTH'(cnt_reg + 1'b1);
                    if (cmd.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ rtl/rob_datapath.sv @@
// ----------------------------------------------------------------------------
// rob_datapath
// slot store, valid bits, head pointer and output register
// ----------------------------------------------------------------------------
module rob_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rob_pkg::item_t       item,
    input  rob_pkg::rob_cmd_t    cmd,
    output rob_pkg::rob_status_t status,
    output logic                 result_valid,
    input  logic                 result_stall,
    output rob_pkg::result_t     result
);

    logic [rob_pkg::DEPTH-1:0]      valid_reg;
    logic [rob_pkg::DEPTH-1:0]      valid_next;
    logic [rob_pkg::DATA_WIDTH-1:0] data_reg [rob_pkg::DEPTH];
    logic [rob_pkg::IDX_WIDTH-1:0]  head_reg;
    logic [rob_pkg::IDX_WIDTH-1:0]  head_next;
    logic [rob_pkg::IDX_WIDTH-1:0]  head_inc;
    logic [rob_pkg::IDX_WIDTH-1:0]  wr_idx;
    logic                           result_valid_reg;
    logic                           result_valid_next;
    rob_pkg::result_t               result_reg;

    // sequence number modulo depth
    assign wr_idx   = rob_pkg::IDX_WIDTH'(item.seq_number);
    assign head_inc = rob_pkg::IDX_WIDTH'(head_reg + 1'b1);

    assign status.head_valid = valid_reg[head_reg];
    assign status.next_valid = valid_reg[head_inc];
    assign status.out_free   = !result_valid_reg || !result_stall;

    always_comb
    begin
        valid_next = valid_reg;
        head_next  = head_reg;
        if (cmd.write)
        begin
            valid_next[wr_idx] = 1'b1;
        end
        if (cmd.emit)
        begin
            valid_next[head_reg] = 1'b0;
            head_next            = head_inc;
        end
        if (cmd.emit)
        begin
            result_valid_next = 1'b1;
        end
        else
        begin
            result_valid_next = result_valid_reg && result_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= '0;
            head_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg        <= valid_next;
            head_reg         <= head_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            data_reg[wr_idx] <= item.payload;
        end
        if (cmd.emit)
        begin
            result_reg.out_seq     <= rob_pkg::SEQ_WIDTH'(head_reg);
            result_reg.out_payload <= data_reg[head_reg];
            result_reg.last_of_run <= cmd.last;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // only a valid head slot is released
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.head_valid)
        else $error("emit from an empty head slot");

    // never overwrite a result beat still waiting
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("emit while output register is held");

    // store and release never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit && cmd.write))
        else $error("write and emit in the same cycle");

    // head steps by one on each release
    a_head_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> head_reg == rob_pkg::IDX_WIDTH'($past(head_reg) + 1'b1))
        else $error("head did not advance by one");

    // released slot is cleared
    a_slot_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> !valid_reg[$past(head_reg)])
        else $error("released slot still valid");

endmodule
